// File: design/pcc_pkg.sv
// Shared types, widths and register codes for the clamped PID controller.
package pcc_pkg;

   // Field and datapath widths
   localparam int unsigned VAL_W   = 32;   // Q16.16 values
   localparam int unsigned GAIN_W  = 24;   // Q8.16 gains
   localparam int unsigned DT_W    = 24;   // Q8.16 time step
   localparam int unsigned ERR_W   = 33;   // target minus measurement
   localparam int unsigned DERR_W  = 34;   // error change
   localparam int unsigned MUL_A_W = 34;
   localparam int unsigned MUL_B_W = 25;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned PTERM_W = 41;
   localparam int unsigned IMAG_W  = 56;   // magnitude of gain_i * error
   localparam int unsigned HIP_W   = 48;   // upper magnitude word times dt
   localparam int unsigned INC_W   = 50;   // signed integrator increment
   localparam int unsigned QUO_W   = 58;   // divider dividend and quotient
   localparam int unsigned SUM_W   = 59;   // full-width sum before clamp

   // Divider retires two quotient bits per cycle
   localparam int unsigned DIV_BITS   = 2;
   localparam int unsigned DIV_CYCLES = QUO_W / DIV_BITS;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

   // Register indexes
   localparam logic [2:0] REG_TARGET = 3'd0;
   localparam logic [2:0] REG_INIT   = 3'd1;
   localparam logic [2:0] REG_GAIN_P = 3'd2;
   localparam logic [2:0] REG_GAIN_I = 3'd3;
   localparam logic [2:0] REG_GAIN_D = 3'd4;
   localparam logic [2:0] REG_OMIN   = 3'd5;
   localparam logic [2:0] REG_OMAX   = 3'd6;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_INC,
      ST_INTEG,
      ST_WAIT_DIV,
      ST_SUM,
      ST_CLAMP
   } state_type;

   // Divider command and status
   typedef struct packed {
      logic              start;
      logic [QUO_W-1:0]  dividend;
      logic [DT_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic [QUO_W-1:0]  quotient;
   } div_sts_type;

   // Clamp result
   typedef struct packed {
      logic              hit;
      logic [VAL_W-1:0]  value;
   } clamp_type;

endpackage

// File: design/pcc_mul.sv
// Shared signed multiplier with registered product.
module pcc_mul (
   input  logic                                clock,
   input  logic signed [pcc_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [pcc_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [pcc_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [pcc_pkg::PROD_W-1:0] prod_in;

   // Form the full-width signed product
   always_comb begin
      prod_in = pcc_pkg::PROD_W'(mul_a) * pcc_pkg::PROD_W'(mul_b);
   end

   // Register the product for the next state
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: design/pcc_div.sv
// Iterative restoring divider, two quotient bits per cycle.
module pcc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pcc_pkg::div_req_type  div_req,
   output pcc_pkg::div_sts_type  div_sts
);

   localparam int unsigned QuoW = pcc_pkg::QUO_W;
   localparam int unsigned DtW  = pcc_pkg::DT_W;
   localparam int unsigned CntW = pcc_pkg::DIV_CNT_W;

   logic              busy_ff,  busy_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [DtW-1:0]    rem_ff,   rem_in;
   logic [QuoW-1:0]   quo_ff,   quo_in;
   logic [DtW-1:0]    dvs_ff,   dvs_in;

   logic [DtW-1:0]    rem_step;
   logic [QuoW-1:0]   quo_step;
   logic [DtW:0]      trial;

   // Run the restoring steps of one cycle
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      trial    = '0;
      for (int k = 0; k < int'(pcc_pkg::DIV_BITS); k++) begin
         trial    = {rem_step, quo_step[QuoW-1]};
         quo_step = {quo_step[QuoW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial       = trial - {1'b0, dvs_ff};
            quo_step[0] = 1'b1;
         end
         rem_step = trial[DtW-1:0];
      end
   end

   // Load on start, advance while busy
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = CntW'(pcc_pkg::DIV_CYCLES - 1);
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = rem_step;
         quo_in   = quo_step;
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.quotient = quo_ff;

endmodule

// File: design/pid_controller_clamped_unit.sv
// Top level of the clamped PID controller: sequencer, registers and datapath.
//
// Usage: each req_ transfer carries one control tick (measured value, time
// step) and yields exactly one rsp_ transfer (clamped drive, saturated flag).
// A transfer happens on a rising edge with valid high and stall low.
// The block takes one tick at a time: req_stall is high from the cycle after
// a tick is taken until its result is loaded into the output register.
// One shared multiplier computes the P, I and D products and the two
// partial products of the I time scaling in turn; a two-bit-per-cycle
// divider forms the D quotient and sets the latency.
// A new tick can be taken as soon as the result of the last one is loaded
// into the output register.
// A held rsp_stall keeps the result in the output register; the next tick is
// accepted and processed meanwhile, and waits at the clamp step until the
// output register frees.
// The csr_ port is an APB-style register file at byte address 4*index;
// writing target_value restarts the loop and reloads the integrator.
// Write registers only while the block is idle.
// Reset (synchronous) sets gains and target to zero, the limits to the full
// signed range, the integrator to zero and the loop to unprimed.
module pid_controller_clamped_unit (
   input  logic                clock,
   input  logic                reset,
   // Input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_measured,
   input  logic        [23:0]  req_delta_time,
   // Result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_drive,
   output logic                rsp_saturated,
   // Configuration port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic        [4:0]   csr_paddr,
   input  logic        [31:0]  csr_pwdata,
   output logic        [31:0]  csr_prdata,
   output logic                csr_pready
);

   localparam int unsigned ValW   = pcc_pkg::VAL_W;
   localparam int unsigned GainW  = pcc_pkg::GAIN_W;
   localparam int unsigned DtW    = pcc_pkg::DT_W;
   localparam int unsigned ErrW   = pcc_pkg::ERR_W;
   localparam int unsigned DerrW  = pcc_pkg::DERR_W;
   localparam int unsigned MulAW  = pcc_pkg::MUL_A_W;
   localparam int unsigned MulBW  = pcc_pkg::MUL_B_W;
   localparam int unsigned ProdW  = pcc_pkg::PROD_W;
   localparam int unsigned FracW  = pcc_pkg::FRAC_W;
   localparam int unsigned PtermW = pcc_pkg::PTERM_W;
   localparam int unsigned ImagW  = pcc_pkg::IMAG_W;
   localparam int unsigned HipW   = pcc_pkg::HIP_W;
   localparam int unsigned IncW   = pcc_pkg::INC_W;
   localparam int unsigned QuoW   = pcc_pkg::QUO_W;
   localparam int unsigned SumW   = pcc_pkg::SUM_W;
   localparam int unsigned PBias  = (1 << FracW) - 1;
   localparam int unsigned HalfW  = 32;

   // Clamp to [lo, hi]; low limit checked first
   function automatic pcc_pkg::clamp_type clamp_value(
      input logic signed [SumW-1:0] x,
      input logic signed [ValW-1:0] lo,
      input logic signed [ValW-1:0] hi
   );
      pcc_pkg::clamp_type res;
      logic signed [SumW-1:0] lo_x;
      logic signed [SumW-1:0] hi_x;
      lo_x = SumW'(lo);
      hi_x = SumW'(hi);
      if (x < lo_x) begin
         res.hit   = 1'b1;
         res.value = lo;
      end else if (x > hi_x) begin
         res.hit   = 1'b1;
         res.value = hi;
      end else begin
         res.hit   = 1'b0;
         res.value = x[ValW-1:0];
      end
      return res;
   endfunction

   // Configuration registers
   logic signed [ValW-1:0]   target_ff, init_ff, omin_ff, omax_ff;
   logic signed [GainW-1:0]  gp_ff, gi_ff, gd_ff;

   // Loop state
   logic signed [ValW-1:0]   integ_ff;
   logic signed [ErrW-1:0]   prev_ff;
   logic                     primed_ff;

   // Per-tick working registers
   pcc_pkg::state_type       state_ff, state_in;
   logic signed [ErrW-1:0]   err_ff;
   logic signed [DerrW-1:0]  derr_ff;
   logic        [DtW-1:0]    dt_ff;
   logic signed [PtermW-1:0] pterm_ff;
   logic        [ImagW-1:0]  imag_ff;
   logic                     ineg_ff;
   logic                     dneg_ff;
   logic        [HipW-1:0]   hip_ff;
   logic signed [IncW-1:0]   inc_ff;
   logic signed [SumW-1:0]   dterm_ff;
   logic signed [SumW-1:0]   sum_ff;

   // Output register
   logic                     rsp_valid_ff;
   logic signed [ValW-1:0]   drive_ff;
   logic                     sat_ff;

   // Shared units
   logic signed [MulAW-1:0]  mul_a;
   logic signed [MulBW-1:0]  mul_b;
   logic signed [ProdW-1:0]  prod_ff;
   pcc_pkg::div_req_type     div_req;
   pcc_pkg::div_sts_type     div_sts;

   // Handshakes and datapath intermediates
   logic                     req_acc;
   logic                     out_free;
   logic                     cfg_wr;
   logic [2:0]               cfg_idx;
   logic signed [ErrW-1:0]   err_in;
   logic signed [ProdW-1:0]  prod_abs;
   logic signed [ProdW-1:0]  p_bias;
   logic signed [ProdW-1:0]  p_adj;
   logic signed [ProdW-1:0]  p_shift;
   logic        [IncW-1:0]   inc_mag;
   logic signed [IncW-1:0]   inc_val;
   logic signed [SumW-1:0]   d_mag;
   pcc_pkg::clamp_type       integ_clamp;
   pcc_pkg::clamp_type       drive_clamp;

   pcc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   pcc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cfg_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_idx  = csr_paddr[4:2];

   // Register read data
   always_comb begin
      case (cfg_idx)
         pcc_pkg::REG_TARGET: csr_prdata = target_ff;
         pcc_pkg::REG_INIT:   csr_prdata = init_ff;
         pcc_pkg::REG_GAIN_P: csr_prdata = ValW'(gp_ff);
         pcc_pkg::REG_GAIN_I: csr_prdata = ValW'(gi_ff);
         pcc_pkg::REG_GAIN_D: csr_prdata = ValW'(gd_ff);
         pcc_pkg::REG_OMIN:   csr_prdata = omin_ff;
         pcc_pkg::REG_OMAX:   csr_prdata = omax_ff;
         default:             csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         init_ff   <= '0;
         gp_ff     <= '0;
         gi_ff     <= '0;
         gd_ff     <= '0;
         omin_ff   <= {1'b1, {(ValW-1){1'b0}}};
         omax_ff   <= {1'b0, {(ValW-1){1'b1}}};
      end else if (cfg_wr) begin
         case (cfg_idx)
            pcc_pkg::REG_TARGET: target_ff <= csr_pwdata;
            pcc_pkg::REG_INIT:   init_ff   <= csr_pwdata;
            pcc_pkg::REG_GAIN_P: gp_ff     <= csr_pwdata[GainW-1:0];
            pcc_pkg::REG_GAIN_I: gi_ff     <= csr_pwdata[GainW-1:0];
            pcc_pkg::REG_GAIN_D: gd_ff     <= csr_pwdata[GainW-1:0];
            pcc_pkg::REG_OMIN:   omin_ff   <= csr_pwdata;
            pcc_pkg::REG_OMAX:   omax_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcc_pkg::ST_IDLE:     if (req_acc) state_in = pcc_pkg::ST_MUL_P;
         pcc_pkg::ST_MUL_P:    state_in = pcc_pkg::ST_MUL_I;
         pcc_pkg::ST_MUL_I:    state_in = pcc_pkg::ST_MUL_D;
         pcc_pkg::ST_MUL_D:    state_in = pcc_pkg::ST_MUL_HI;
         pcc_pkg::ST_MUL_HI:   state_in = pcc_pkg::ST_MUL_LO;
         pcc_pkg::ST_MUL_LO:   state_in = pcc_pkg::ST_INC;
         pcc_pkg::ST_INC:      state_in = pcc_pkg::ST_INTEG;
         pcc_pkg::ST_INTEG:    state_in = pcc_pkg::ST_WAIT_DIV;
         pcc_pkg::ST_WAIT_DIV: if (!div_sts.busy) state_in = pcc_pkg::ST_SUM;
         pcc_pkg::ST_SUM:      state_in = pcc_pkg::ST_CLAMP;
         pcc_pkg::ST_CLAMP:    if (out_free) state_in = pcc_pkg::ST_IDLE;
         default:              state_in = pcc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer outputs: multiplier operands, divider start, input stall
   always_comb begin
      mul_a            = '0;
      mul_b            = '0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_abs[QuoW-1:0];
      div_req.divisor  = dt_ff;
      req_stall        = (state_ff != pcc_pkg::ST_IDLE);
      case (state_ff)
         pcc_pkg::ST_MUL_P: begin
            mul_a = MulAW'(err_ff);
            mul_b = MulBW'(gp_ff);
         end
         pcc_pkg::ST_MUL_I: begin
            mul_a = MulAW'(err_ff);
            mul_b = MulBW'(gi_ff);
         end
         pcc_pkg::ST_MUL_D: begin
            mul_a = MulAW'(derr_ff);
            mul_b = MulBW'(gd_ff);
         end
         pcc_pkg::ST_MUL_HI: begin
            mul_a         = $signed({{(MulAW-(ImagW-HalfW)){1'b0}}, imag_ff[ImagW-1:HalfW]});
            mul_b         = $signed({{(MulBW-DtW){1'b0}}, dt_ff});
            div_req.start = (dt_ff != '0);
         end
         pcc_pkg::ST_MUL_LO: begin
            mul_a = $signed({{(MulAW-HalfW){1'b0}}, imag_ff[HalfW-1:0]});
            mul_b = $signed({{(MulBW-DtW){1'b0}}, dt_ff});
         end
         default: ;
      endcase
   end

   // Datapath arithmetic on the registered product
   always_comb begin
      err_in      = ErrW'(target_ff) - ErrW'(req_measured);
      prod_abs    = prod_ff[ProdW-1] ? -prod_ff : prod_ff;
      p_bias      = prod_ff[ProdW-1] ? ProdW'(PBias) : '0;
      p_adj       = prod_ff + p_bias;
      p_shift     = p_adj >>> FracW;
      inc_mag     = IncW'(hip_ff) + IncW'(prod_ff[ImagW-1:HalfW]);
      inc_val     = ineg_ff ? -$signed(inc_mag) : $signed(inc_mag);
      d_mag       = $signed(SumW'(div_sts.quotient));
      integ_clamp = clamp_value(SumW'(integ_ff) + SumW'(inc_ff), omin_ff, omax_ff);
      drive_clamp = clamp_value(sum_ff, omin_ff, omax_ff);
   end

   // Loop state: restart on target write, update per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff  <= '0;
         prev_ff   <= '0;
         primed_ff <= 1'b0;
      end else if (cfg_wr && cfg_idx == pcc_pkg::REG_TARGET) begin
         integ_ff  <= init_ff;
         prev_ff   <= '0;
         primed_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            prev_ff   <= err_in;
            primed_ff <= 1'b1;
         end
         if (state_ff == pcc_pkg::ST_INTEG) begin
            integ_ff <= integ_clamp.value;
         end
      end
   end

   // Working registers, captured as the sequencer walks through the tick
   always_ff @(posedge clock) begin
      if (req_acc) begin
         err_ff  <= err_in;
         derr_ff <= primed_ff ? (DerrW'(err_in) - DerrW'(prev_ff)) : '0;
         dt_ff   <= req_delta_time;
      end
      case (state_ff)
         pcc_pkg::ST_MUL_I:  pterm_ff <= p_shift[PtermW-1:0];
         pcc_pkg::ST_MUL_D: begin
            imag_ff <= prod_abs[ImagW-1:0];
            ineg_ff <= prod_ff[ProdW-1];
         end
         pcc_pkg::ST_MUL_HI: dneg_ff <= prod_ff[ProdW-1];
         pcc_pkg::ST_MUL_LO: hip_ff  <= prod_ff[HipW-1:0];
         pcc_pkg::ST_INC:    inc_ff  <= inc_val;
         pcc_pkg::ST_WAIT_DIV: begin
            if (dt_ff == '0) begin
               dterm_ff <= '0;
            end else begin
               dterm_ff <= dneg_ff ? -d_mag : d_mag;
            end
         end
         pcc_pkg::ST_SUM: sum_ff <= SumW'(pterm_ff) + SumW'(integ_ff) + dterm_ff;
         default: ;
      endcase
   end

   // Output register: load at the clamp step, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == pcc_pkg::ST_CLAMP && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pcc_pkg::ST_CLAMP && out_free) begin
         drive_ff <= drive_clamp.value;
         sat_ff   <= drive_clamp.hit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = drive_ff;
   assign rsp_saturated = sat_ff;

   // A taken tick holds off the next one
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("input not stalled after transfer");

   // The divider is never left running while the sequencer is idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcc_pkg::ST_IDLE) |-> !div_sts.busy)
      else $error("divider busy while idle");

   // A saturated result sits exactly on one of the limits
   a_sat_on_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_drive == omin_ff || rsp_drive == omax_ff))
      else $error("saturated drive not at a limit");

endmodule
